// ===== src/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and constants for the sorted list store.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned VAL_W        = 32;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd99999;

  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_AT  = 2'd1,
    CMD_REMOVE_VAL = 2'd2,
    CMD_GET        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // request broadcast to every cell; go is set only when the command changes the store
  typedef struct packed {
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
    logic                    go;
  } req_t;

endpackage

// ===== src/sorted_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_list_store_unit
// Sorted store of signed 32-bit values built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one command per clock unless a held result stalls in_ready, and
// returns its result in the next cycle, held in an output register until
// taken. Every cell compares its entry with the request in parallel and
// moves left or right in that same cycle; the CAPACITY cells and the index
// encoder set the critical path. No clearing pass is needed after reset.
module sorted_list_store_unit
  import sls_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic signed [VAL_W-1:0] value,
  input  logic [3:0]              position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] data_out,
  output logic [3:0]              found_index,
  output logic [4:0]              count
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = CNT_W + 4;

  logic [CNT_W-1:0]        fill, fill_next;
  req_t                    req;
  cmd_t                    cmd;
  logic                    accept, full, pos_ok, found;
  logic signed [VAL_W-1:0] entry   [CAPACITY];
  logic [CAPACITY-1:0]     mark, ge, eq, at_pos, cvalid, sel;
  logic [IDX_W-1:0]        ins_idx, val_idx;
  logic signed [VAL_W-1:0] pos_data;

  status_t                 status_next;
  logic signed [VAL_W-1:0] data_next;
  logic [IDX_W-1:0]        idx_next;

  assign cmd      = cmd_t'(command);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (fill == CNT_W'(CAPACITY));
  assign pos_ok   = (CMP_W'(position) < CMP_W'(fill));
  assign found    = |eq;

  always_comb begin
    req.cmd   = cmd;
    req.value = value;
    case (cmd)
      CMD_INSERT:     req.go = accept && !full;
      CMD_REMOVE_AT:  req.go = accept && pos_ok;
      CMD_REMOVE_VAL: req.go = accept && found;
      default:        req.go = 1'b0;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cvalid[i] = (CNT_W'(i) < fill);
    assign at_pos[i] = (CMP_W'(i) >= CMP_W'(position));
    assign sel[i]    = (CMP_W'(i) == CMP_W'(position));

    sls_cell u_cell (
      .clk         (clk),
      .req         (req),
      .valid       (cvalid[i]),
      .at_pos      (at_pos[i]),
      .left_mark   ((i == 0) ? 1'b0 : mark[(i == 0) ? 0 : i-1]),
      .left_entry  (entry[(i == 0) ? 0 : i-1]),
      .right_entry (entry[(i == CAPACITY-1) ? i : i+1]),
      .entry       (entry[i]),
      .mark        (mark[i]),
      .ge          (ge[i]),
      .eq          (eq[i])
    );
  end

  // boundary of a monotonic mask gives the index; position read is one-hot AND-OR
  always_comb begin
    ins_idx  = '0;
    val_idx  = '0;
    pos_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mark[i] && (i == 0 || !mark[(i == 0) ? 0 : i-1])) ins_idx |= IDX_W'(i);
      if (ge[i] && (i == 0 || !ge[(i == 0) ? 0 : i-1]))     val_idx |= IDX_W'(i);
      if (sel[i]) pos_data |= entry[i];
    end
  end

  always_comb begin
    status_next = ST_MISS;
    data_next   = MISS_VALUE;
    idx_next    = '0;
    fill_next   = fill;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          data_next   = value;
          idx_next    = ins_idx;
          fill_next   = fill + 1'b1;
        end
      end
      CMD_REMOVE_AT, CMD_GET: begin
        if (pos_ok) begin
          status_next = ST_DONE;
          data_next   = pos_data;
          idx_next    = IDX_W'(position);
          if (cmd == CMD_REMOVE_AT) fill_next = fill - 1'b1;
        end
      end
      CMD_REMOVE_VAL: begin
        if (found) begin
          status_next = ST_DONE;
          data_next   = value;
          idx_next    = val_idx;
          fill_next   = fill - 1'b1;
        end
      end
      default: status_next = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) fill <= fill_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      data_out    <= data_next;
      found_index <= 4'(idx_next);
      count       <= 5'(fill_next);
    end
  end

endmodule

// ===== src/sls_cell.sv =====
// ----------------------------------------------------------------------------
// sls_cell
// One slot of the sorted row: holds an entry, compares it against the
// broadcast value and moves data to or from its neighbours.
// ----------------------------------------------------------------------------
module sls_cell
  import sls_pkg::*;
(
  input  logic                    clk,
  input  req_t                    req,
  input  logic                    valid,        // slot lies below the fill level
  input  logic                    at_pos,       // slot index >= requested position
  input  logic                    left_mark,
  input  logic signed [VAL_W-1:0] left_entry,
  input  logic signed [VAL_W-1:0] right_entry,
  output logic signed [VAL_W-1:0] entry,
  output logic                    mark,         // insert goes at or before this slot
  output logic                    ge,
  output logic                    eq
);

  logic signed [VAL_W-1:0] entry_next;

  assign mark = !valid || (entry > req.value);
  assign ge   = valid && (entry >= req.value);
  assign eq   = valid && (entry == req.value);

  always_comb begin
    entry_next = entry;
    if (req.go) begin
      case (req.cmd)
        CMD_INSERT: begin
          if (left_mark) begin
            entry_next = left_entry;
          end else if (mark) begin
            entry_next = req.value;
          end
        end
        CMD_REMOVE_AT: begin
          if (at_pos) entry_next = right_entry;
        end
        CMD_REMOVE_VAL: begin
          if (ge) entry_next = right_entry;
        end
        default: entry_next = entry;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== src/sls_checker.sv =====
// ----------------------------------------------------------------------------
// sls_checker
// Port-level checks for the sorted list store, bound to the top level.
// ----------------------------------------------------------------------------
module sls_checker
  import sls_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              command,
  input logic signed [VAL_W-1:0] value,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic signed [VAL_W-1:0] data_out,
  input logic [3:0]              found_index,
  input logic [4:0]              count
);

  // every transaction yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transaction");

  // a miss or a full store reports the miss value at index zero
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_MISS)
      |-> data_out == MISS_VALUE && found_index == 4'd0)
    else $error("miss result carries wrong fields");

  // full status only when the store holds CAPACITY entries
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == 5'(CAPACITY))
    else $error("full status with store not full");

  // a successful insert echoes the inserted value and the count cannot be zero
  a_insert_echo: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_INSERT
      |=> (status == ST_FULL) || (data_out == $past(value) && count != 5'd0))
    else $error("insert result does not echo value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status))
    else $error("stalled result changed");

endmodule

bind sorted_list_store_unit sls_checker #(.CAPACITY(CAPACITY)) u_sls_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_list_store_unit. Commands are driven over
// the request channel with random gaps; a local model of the ordered store
// predicts each reply, and every reply taken from the result channel is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import sls_pkg::*;

  localparam int unsigned SLOTS       = DEF_CAPACITY;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] data;
    logic [3:0]              index;
    logic [4:0]              count;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              command = CMD_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic [3:0]              position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] data_out;
  logic [3:0]              found_index;
  logic [4:0]              count;

  // local copy of the ordered store
  logic signed [VAL_W-1:0] list_vals [SLOTS];
  int                      list_fill = 0;

  reply_t reply_q [$];
  int     errors    = 0;
  int     cycles    = 0;
  bit     idle_on   = 1'b1;
  int     hold_req  = 0;
  int     hold_left = 0;
  int     stall_left = 0;

  sorted_list_store_unit #(.CAPACITY(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .value(value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_out(data_out), .found_index(found_index), .count(count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d (0x%08h) want %0d (0x%08h) at cycle %0d",
             what, $signed(got), got, $signed(want), want, cycles);
  endtask

  // drop entry idx and close the gap
  task automatic drop_entry(input int idx);
    for (int i = idx; i + 1 < list_fill; i++) list_vals[i] = list_vals[i + 1];
    list_fill--;
  endtask

  task automatic predict_reply(input cmd_t c, input logic signed [VAL_W-1:0] v,
                               input logic [3:0] p);
    reply_t r;
    int     slot;
    bit     hit;
    r.status = ST_MISS;
    r.data   = MISS_VALUE;
    r.index  = '0;
    hit      = 1'b0;
    case (c)
      CMD_INSERT: begin
        if (list_fill >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot = list_fill;
          for (int i = 0; i < list_fill; i++) begin
            if (!hit && list_vals[i] > v) begin
              slot = i;
              hit  = 1'b1;
            end
          end
          for (int i = list_fill; i > slot; i--) list_vals[i] = list_vals[i - 1];
          list_vals[slot] = v;
          list_fill++;
          r.status = ST_DONE;
          r.data   = v;
          r.index  = slot[3:0];
        end
      end
      CMD_REMOVE_AT, CMD_GET: begin
        if (int'(p) < list_fill) begin
          r.status = ST_DONE;
          r.data   = list_vals[p];
          r.index  = p;
          if (c == CMD_REMOVE_AT) drop_entry(int'(p));
        end
      end
      default: begin
        for (int i = 0; i < list_fill; i++) begin
          if (!hit && list_vals[i] == v) begin
            hit      = 1'b1;
            r.status = ST_DONE;
            r.data   = v;
            r.index  = i[3:0];
            drop_entry(i);
          end
        end
      end
    endcase
    r.count = list_fill[4:0];
    reply_q.push_back(r);
  endtask

  // valid is only lowered ahead of an idle gap, so back-to-back transactions
  // never see a low and a high in the same step
  task automatic send_cmd(input cmd_t c, input logic signed [VAL_W-1:0] v,
                          input logic [3:0] p);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    value    <= v;
    position <= p;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_reply(c, v, p);
  endtask

  // receiver: random stall bursts, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected transaction, data_out", data_out, '0);
      end else begin
        want = reply_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (data_out !== want.data) report_mismatch("data_out", data_out, want.data);
        if (found_index !== want.index)
          report_mismatch("found_index", 32'(found_index), 32'(want.index));
        if (count !== want.count)
          report_mismatch("count", 32'(count), 32'(want.count));
      end
    end
  end

  task automatic send_random(input int insert_pct);
    cmd_t                    c;
    logic signed [VAL_W-1:0] v;
    logic [3:0]              p;
    int                      r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      c = CMD_INSERT;
    end else begin
      r = $urandom_range(0, 2);
      c = (r == 0) ? CMD_REMOVE_AT : (r == 1) ? CMD_REMOVE_VAL : CMD_GET;
    end
    // mostly values already held or clustered, so removals hit and ties occur
    r = $urandom_range(0, 9);
    if (r < 4 && list_fill > 0) v = list_vals[$urandom_range(0, list_fill - 1)];
    else if (r < 7) v = int'($urandom_range(0, 15)) - 8;
    else v = $urandom();
    if (list_fill > 0 && $urandom_range(0, 3) != 0) p = 4'($urandom_range(0, list_fill - 1));
    else p = 4'($urandom_range(0, 15));
    send_cmd(c, v, p);
  endtask

  task automatic test_empty_misses();
    send_cmd(CMD_GET, 32'sd0, 4'd0);
    send_cmd(CMD_REMOVE_AT, 32'sd0, 4'd15);
    send_cmd(CMD_REMOVE_VAL, 32'sd5, 4'd0);
  endtask

  task automatic test_extremes();
    send_cmd(CMD_INSERT, 32'sh7fffffff, 4'd0);
    send_cmd(CMD_INSERT, 32'sh80000000, 4'd0);
    send_cmd(CMD_INSERT, 32'sd0, 4'd0);
    send_cmd(CMD_INSERT, -32'sd1, 4'd0);
    send_cmd(CMD_INSERT, MISS_VALUE, 4'd0);
    send_cmd(CMD_GET, 32'sd0, 4'd4);
    send_cmd(CMD_GET, 32'sd0, 4'd5);          // one past the end
    send_cmd(CMD_REMOVE_VAL, 32'sd7, 4'd0);   // absent
    send_cmd(CMD_REMOVE_VAL, 32'sh80000000, 4'd0);
    send_cmd(CMD_REMOVE_AT, 32'sd0, 4'd3);
  endtask

  // fill to capacity with ties, one insert too many, then read and remove the last slot
  task automatic test_full_store();
    while (list_fill < SLOTS) send_cmd(CMD_INSERT, 32'sd0, 4'd0);
    send_cmd(CMD_INSERT, 32'sd1, 4'd0);
    send_cmd(CMD_GET, 32'sd0, 4'd15);
    send_cmd(CMD_REMOVE_AT, 32'sd0, 4'd15);
  endtask

  task automatic test_random_mix();
    int mix [4] = '{80, 50, 20, 65};
    for (int blk = 0; blk < 12; blk++) begin
      idle_on = (blk % 3 != 2);
      repeat (100) send_random(mix[blk % 4]);
    end
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_back_pressure();
    idle_on  = 1'b0;
    hold_req = 200;
    repeat (40) send_random(50);
    idle_on = 1'b1;
  endtask

  task automatic test_final_burst();
    idle_on = 1'b0;
    repeat (100) send_random(50);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_misses();
    test_extremes();
    test_full_store();
    test_random_mix();
    test_back_pressure();
    test_final_burst();
    in_valid <= 1'b0;
    while (reply_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
